>>> rtl/vbmm_pkg.sv
// Shared types and constants for the video bus memory map.
`default_nettype none

package vbmm_pkg;

    localparam int ADDR_W             = 16;
    localparam int BUS_AW             = 14;
    localparam int DATA_W             = 8;
    localparam int MODE_W             = 2;
    localparam int PATTERN_BYTES_DEF  = 8192;
    localparam int NAMETABLE_BYTES_DEF = 2048;
    localparam int PALETTE_BYTES      = 32;
    localparam int PALETTE_AW         = $clog2(PALETTE_BYTES);
    localparam int HALF_AW            = 10;

    localparam logic [BUS_AW-1:0] PATTERN_END   = 14'h1FFF;
    localparam logic [BUS_AW-1:0] NAMETABLE_END = 14'h3EFF;
    localparam logic [DATA_W-1:0] FAULT_BYTE    = 8'h55;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MIRROR_HORIZONTAL = 2'd0,
        MIRROR_VERTICAL   = 2'd1
    } t_mirror;

    typedef enum logic [1:0] {
        TGT_PATTERN   = 2'd0,
        TGT_NAMETABLE = 2'd1,
        TGT_PALETTE   = 2'd2
    } t_target;

    typedef struct packed {
        t_target target;
        logic    fault;
    } t_sel;

endpackage

`default_nettype wire

>>> rtl/vbmm_if.sv
// Request, response and configuration channel interfaces.
`default_nettype none

interface vbmm_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [vbmm_pkg::ADDR_W-1:0]  address;
    logic [vbmm_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

interface vbmm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [vbmm_pkg::DATA_W-1:0]  read_data;
    logic                         mirror_fault;

    modport source (output valid, output read_data, output mirror_fault, input ready);
    modport sink   (input valid, input read_data, input mirror_fault, output ready);
endinterface

interface vbmm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [vbmm_pkg::MODE_W-1:0]  mirror_mode;

    modport source (output valid, output mirror_mode, input ready);
    modport sink   (input valid, input mirror_mode, output ready);
endinterface

`default_nettype wire

>>> rtl/vbmm_decode.sv
// Address decode: target memory, entry indexes and mirroring fault.
`default_nettype none

module vbmm_decode #(
    parameter int PATTERN_BYTES   = vbmm_pkg::PATTERN_BYTES_DEF,
    parameter int NAMETABLE_BYTES = vbmm_pkg::NAMETABLE_BYTES_DEF
) (
    input  wire logic [vbmm_pkg::ADDR_W-1:0]      i_address,
    input  wire logic [vbmm_pkg::MODE_W-1:0]      i_mirror_mode,
    output vbmm_pkg::t_sel                        o_sel,
    output logic [$clog2(PATTERN_BYTES)-1:0]      o_pat_idx,
    output logic [$clog2(NAMETABLE_BYTES)-1:0]    o_nt_idx,
    output logic [vbmm_pkg::PALETTE_AW-1:0]       o_pal_idx
);

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);

    logic [vbmm_pkg::BUS_AW-1:0]     bus_addr;
    logic                            half;
    logic                            bad_mode;
    logic [vbmm_pkg::PALETTE_AW-1:0] pal_raw;

    assign bus_addr = i_address[vbmm_pkg::BUS_AW-1:0];

    always_comb begin
        bad_mode = 1'b0;
        half     = 1'b0;
        unique case (i_mirror_mode)
            vbmm_pkg::MIRROR_HORIZONTAL: begin
                half = bus_addr[11];
            end
            vbmm_pkg::MIRROR_VERTICAL: begin
                half = bus_addr[10];
            end
            default: begin
                bad_mode = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_sel.fault = 1'b0;
        priority if (bus_addr <= vbmm_pkg::PATTERN_END) begin
            o_sel.target = vbmm_pkg::TGT_PATTERN;
        end else if (bus_addr <= vbmm_pkg::NAMETABLE_END) begin
            o_sel.target = vbmm_pkg::TGT_NAMETABLE;
            o_sel.fault  = bad_mode;
        end else begin
            o_sel.target = vbmm_pkg::TGT_PALETTE;
        end
    end

    assign o_pat_idx = PAT_AW'(bus_addr);
    assign o_nt_idx  = NT_AW'({half, bus_addr[vbmm_pkg::HALF_AW-1:0]});

    assign pal_raw = bus_addr[vbmm_pkg::PALETTE_AW-1:0];

    always_comb begin
        o_pal_idx = pal_raw;
        if (pal_raw[4] && (pal_raw[1:0] == 2'b00)) begin
            o_pal_idx[4] = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vbmm_mem_bank.sv
// Pattern, nametable and palette memories with registered read data.
`default_nettype none

module vbmm_mem_bank #(
    parameter int PATTERN_BYTES   = vbmm_pkg::PATTERN_BYTES_DEF,
    parameter int NAMETABLE_BYTES = vbmm_pkg::NAMETABLE_BYTES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic                                i_write,
    input  wire vbmm_pkg::t_sel                      i_sel,
    input  wire logic [$clog2(PATTERN_BYTES)-1:0]    i_pat_idx,
    input  wire logic [$clog2(NAMETABLE_BYTES)-1:0]  i_nt_idx,
    input  wire logic [vbmm_pkg::PALETTE_AW-1:0]     i_pal_idx,
    input  wire logic [vbmm_pkg::DATA_W-1:0]         i_wdata,
    output logic [vbmm_pkg::DATA_W-1:0]              o_pat_q,
    output logic [vbmm_pkg::DATA_W-1:0]              o_nt_q,
    output logic [vbmm_pkg::DATA_W-1:0]              o_pal_q
);

    logic [vbmm_pkg::DATA_W-1:0] r_pat_mem [PATTERN_BYTES];
    logic [vbmm_pkg::DATA_W-1:0] r_nt_mem  [NAMETABLE_BYTES];
    logic [vbmm_pkg::DATA_W-1:0] r_pal_mem [vbmm_pkg::PALETTE_BYTES];

    logic pat_en;
    logic nt_en;
    logic pal_en;

    assign pat_en = i_en && (i_sel.target == vbmm_pkg::TGT_PATTERN);
    assign nt_en  = i_en && (i_sel.target == vbmm_pkg::TGT_NAMETABLE) && !i_sel.fault;
    assign pal_en = i_en && (i_sel.target == vbmm_pkg::TGT_PALETTE);

    always_ff @(posedge i_clk) begin
        if (pat_en) begin
            if (i_write) begin
                r_pat_mem[i_pat_idx] <= i_wdata;
            end else begin
                o_pat_q <= r_pat_mem[i_pat_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (nt_en) begin
            if (i_write) begin
                r_nt_mem[i_nt_idx] <= i_wdata;
            end else begin
                o_nt_q <= r_nt_mem[i_nt_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_en) begin
            if (i_write) begin
                r_pal_mem[i_pal_idx] <= i_wdata;
            end else begin
                o_pal_q <= r_pal_mem[i_pal_idx];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/video_bus_memory_map.sv
// Top level of the video bus memory map: handshakes, read pipeline, mode register.
//
//   channel  direction  payload
//   i_req    in         operation, address, write_data
//   o_rsp    out        read_data, mirror_fault
//   i_cfg    in         mirror_mode
//
// One request per cycle unless the read stage is held; a read returns through the
// registered memory read and then the output register.
// Writes complete in the cycle they are accepted and return nothing.
// A stalled response holds the read stage; requests stop only when both are full.
// Synchronous active-low reset clears the mode register and all valid flags.
`default_nettype none

module video_bus_memory_map #(
    parameter int PATTERN_BYTES   = vbmm_pkg::PATTERN_BYTES_DEF,
    parameter int NAMETABLE_BYTES = vbmm_pkg::NAMETABLE_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vbmm_req_if.sink   i_req,
    vbmm_rsp_if.source o_rsp,
    vbmm_cfg_if.sink   i_cfg
);

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);

    logic [vbmm_pkg::MODE_W-1:0] r_mirror_mode;
    logic [vbmm_pkg::MODE_W-1:0] n_mirror_mode;

    logic                        r_s1_valid;
    logic                        n_s1_valid;
    vbmm_pkg::t_sel              r_s1_sel;

    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [vbmm_pkg::DATA_W-1:0] r_out_data;
    logic                        r_out_fault;

    vbmm_pkg::t_sel              dec_sel;
    logic [PAT_AW-1:0]           pat_idx;
    logic [NT_AW-1:0]            nt_idx;
    logic [vbmm_pkg::PALETTE_AW-1:0] pal_idx;
    logic [vbmm_pkg::DATA_W-1:0] pat_q;
    logic [vbmm_pkg::DATA_W-1:0] nt_q;
    logic [vbmm_pkg::DATA_W-1:0] pal_q;
    logic [vbmm_pkg::DATA_W-1:0] s1_data;

    logic req_fire;
    logic req_write;
    logic out_free;
    logic s1_move;

    assign i_cfg.ready = 1'b1;
    assign n_mirror_mode = i_cfg.valid ? i_cfg.mirror_mode : r_mirror_mode;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || s1_move;
    assign req_fire    = i_req.valid && i_req.ready;
    assign req_write   = (i_req.operation == vbmm_pkg::OP_WRITE);

    vbmm_decode #(
        .PATTERN_BYTES   (PATTERN_BYTES),
        .NAMETABLE_BYTES (NAMETABLE_BYTES)
    ) u_decode (
        .i_address     (i_req.address),
        .i_mirror_mode (r_mirror_mode),
        .o_sel         (dec_sel),
        .o_pat_idx     (pat_idx),
        .o_nt_idx      (nt_idx),
        .o_pal_idx     (pal_idx)
    );

    vbmm_mem_bank #(
        .PATTERN_BYTES   (PATTERN_BYTES),
        .NAMETABLE_BYTES (NAMETABLE_BYTES)
    ) u_mem_bank (
        .i_clk     (i_clk),
        .i_en      (req_fire),
        .i_write   (req_write),
        .i_sel     (dec_sel),
        .i_pat_idx (pat_idx),
        .i_nt_idx  (nt_idx),
        .i_pal_idx (pal_idx),
        .i_wdata   (i_req.write_data),
        .o_pat_q   (pat_q),
        .o_nt_q    (nt_q),
        .o_pal_q   (pal_q)
    );

    always_comb begin
        if (r_s1_sel.fault) begin
            s1_data = vbmm_pkg::FAULT_BYTE;
        end else if (r_s1_sel.target == vbmm_pkg::TGT_PATTERN) begin
            s1_data = pat_q;
        end else if (r_s1_sel.target == vbmm_pkg::TGT_NAMETABLE) begin
            s1_data = nt_q;
        end else begin
            s1_data = pal_q;
        end
    end

    assign n_s1_valid  = (req_fire && !req_write) || (r_s1_valid && !s1_move);
    assign n_out_valid = s1_move || (r_out_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_mode <= vbmm_pkg::MIRROR_HORIZONTAL;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_mirror_mode <= n_mirror_mode;
            r_s1_valid    <= n_s1_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire && !req_write) begin
            r_s1_sel <= dec_sel;
        end
        if (s1_move) begin
            r_out_data  <= s1_data;
            r_out_fault <= r_s1_sel.fault;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out_data;
    assign o_rsp.mirror_fault = r_out_fault;

`ifndef SYNTHESIS
    a_read_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && !req_write) |=> r_s1_valid)
        else $error("accepted read did not reach the read stage");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && req_write && !r_s1_valid) |=> !r_s1_valid)
        else $error("write request produced a read stage entry");

    a_s1_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |-> !req_fire)
        else $error("request accepted over a held read stage");

    a_fault_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault) |-> (r_out_data == vbmm_pkg::FAULT_BYTE))
        else $error("fault response without fault byte");
`endif

endmodule

`default_nettype wire
